// ===== src/tlca_pkg.sv =====
// Shared types and constants of the binary-lifting common-ancestor block.
package tlca_pkg;

	localparam int NODE_W        = 10;
	localparam int MAX_NODES_DEF = 1024;
	localparam int LEVELS_DEF    = 11;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RB_RD1,
		ST_RB_RD2,
		ST_RB_WR,
		ST_DP_START,
		ST_DP_RD,
		ST_DP_STEP,
		ST_Q_RDA,
		ST_Q_RDB,
		ST_Q_SWAP,
		ST_LF_STEP,
		ST_LF_TAKE,
		ST_CMP,
		ST_BX,
		ST_BY,
		ST_BC,
		ST_FIN_RD,
		ST_FIN_TAKE,
		ST_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_RB_RD1,
		OP_RB_RD2,
		OP_RB_WR,
		OP_DP_START,
		OP_DP_RD,
		OP_DP_STEP,
		OP_Q_RDA,
		OP_Q_RDB,
		OP_Q_SWAP,
		OP_KDEC,
		OP_LF_RD,
		OP_LF_TAKE,
		OP_KINIT,
		OP_BX,
		OP_BY,
		OP_BC,
		OP_FIN_RD,
		OP_RES_X,
		OP_RES_DATA,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic is_query;
		logic in_range;
		logic stale;
		logic k_zero;
		logic k_last;
		logic n_last;
		logic diff_bit;
		logic x_eq_y;
		logic out_free;
	} status_t;

endpackage

// ===== src/tree_lca_binary_lifting.sv =====
// Top level of the binary-lifting lowest-common-ancestor block.
// Input stream: s_axis_tuser selects the item kind (0 = load parent, 1 = query),
// s_axis_tdata carries the two node numbers. Output stream: one ancestor per query.
// A load of a nonzero node writes one parent entry and marks the jump table stale;
// it gives no output item.
// The first query after any load rebuilds the table: a read, a second read and a write
// per entry for each of LEVELS-1 levels over all nodes, then a depth pass over every
// node through all levels, all through the single read port of the jump-table RAM.
// A query then reads both depths, lifts the deeper node level by level and compares;
// unless the two are equal, it lifts both jointly level by level and reads their final
// parent as the result. Out-of-range queries answer 0 without a rebuild or lift.
// One item is worked at a time; s_axis_tready is high only when the block is idle.
// The result sits in an output register; while the receiver stalls it holds there,
// the next item is still taken, and its result waits until the register frees.
// Reset clears the control state, sets node_count to 1 and marks the table stale.
// Table contents are undefined after reset until parents are loaded.
module tree_lca_binary_lifting #(
	parameter int MAX_NODES = tlca_pkg::MAX_NODES_DEF,
	parameter int LEVELS    = tlca_pkg::LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // node_a [9:0], node_b [19:10], zero [23:20]
	input  logic        s_axis_tuser,  // func [0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // ancestor [9:0], zero [15:10]
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata      // node_count
);
	import tlca_pkg::*;

	cmd_t              cmd;
	status_t           stat;
	logic [NODE_W-1:0] anc;

	tlca_ctrl #(.LEVELS(LEVELS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tlca_dp #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_func   (s_axis_tuser),
		.in_a      (s_axis_tdata[9:0]),
		.in_b      (s_axis_tdata[19:10]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_anc   (anc)
	);

	assign m_axis_tdata = {6'd0, anc};

`ifndef ASSERT_OFF
	// a load finishes in its accept cycle
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> s_axis_tready)
		else $error("load item did not complete in one cycle");

	// a query always leaves the block busy once accepted
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
		else $error("query accepted without busy period");

	// the depth read of a query always sees a fresh table
	a_fresh_table: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_Q_RDA) |=> !stat.stale)
		else $error("query lifting started on a stale table");
`endif
endmodule

// ===== src/tlca_ram.sv =====
// Generic simple dual-port RAM with registered read.
module tlca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/tlca_ctrl.sv =====
// Sequencer for table rebuild, depth pass and query lifting.
module tlca_ctrl #(
	parameter int LEVELS = tlca_pkg::LEVELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tlca_pkg::status_t stat,
	output tlca_pkg::cmd_t    cmd
);
	import tlca_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && stat.is_query) begin
					if (!stat.in_range) begin
						state_d = ST_DONE;
					end else if (stat.stale) begin
						state_d = (LEVELS == 1) ? ST_DP_START : ST_RB_RD1;
					end else begin
						state_d = ST_Q_RDA;
					end
				end
			end
			ST_RB_RD1:   state_d = ST_RB_RD2;
			ST_RB_RD2:   state_d = ST_RB_WR;
			ST_RB_WR: begin
				state_d = (stat.n_last && stat.k_last) ? ST_DP_START : ST_RB_RD1;
			end
			ST_DP_START: state_d = ST_DP_RD;
			ST_DP_RD:    state_d = ST_DP_STEP;
			ST_DP_STEP: begin
				if (!stat.k_zero) begin
					state_d = ST_DP_RD;
				end else begin
					state_d = stat.n_last ? ST_Q_RDA : ST_DP_START;
				end
			end
			ST_Q_RDA:    state_d = ST_Q_RDB;
			ST_Q_RDB:    state_d = ST_Q_SWAP;
			ST_Q_SWAP:   state_d = ST_LF_STEP;
			ST_LF_STEP: begin
				if (stat.diff_bit) begin
					state_d = ST_LF_TAKE;
				end else begin
					state_d = stat.k_zero ? ST_CMP : ST_LF_STEP;
				end
			end
			ST_LF_TAKE:  state_d = stat.k_zero ? ST_CMP : ST_LF_STEP;
			ST_CMP:      state_d = stat.x_eq_y ? ST_DONE : ST_BX;
			ST_BX:       state_d = ST_BY;
			ST_BY:       state_d = ST_BC;
			ST_BC:       state_d = stat.k_zero ? ST_FIN_RD : ST_BX;
			ST_FIN_RD:   state_d = ST_FIN_TAKE;
			ST_FIN_TAKE: state_d = ST_DONE;
			ST_DONE:     state_d = stat.out_free ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NOP;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.op   = in_valid ? OP_ACCEPT : OP_NOP;
			end
			ST_RB_RD1:   cmd.op = OP_RB_RD1;
			ST_RB_RD2:   cmd.op = OP_RB_RD2;
			ST_RB_WR:    cmd.op = OP_RB_WR;
			ST_DP_START: cmd.op = OP_DP_START;
			ST_DP_RD:    cmd.op = OP_DP_RD;
			ST_DP_STEP:  cmd.op = OP_DP_STEP;
			ST_Q_RDA:    cmd.op = OP_Q_RDA;
			ST_Q_RDB:    cmd.op = OP_Q_RDB;
			ST_Q_SWAP:   cmd.op = OP_Q_SWAP;
			ST_LF_STEP:  cmd.op = stat.diff_bit ? OP_LF_RD : OP_KDEC;
			ST_LF_TAKE:  cmd.op = OP_LF_TAKE;
			ST_CMP:      cmd.op = stat.x_eq_y ? OP_RES_X : OP_KINIT;
			ST_BX:       cmd.op = OP_BX;
			ST_BY:       cmd.op = OP_BY;
			ST_BC:       cmd.op = OP_BC;
			ST_FIN_RD:   cmd.op = OP_FIN_RD;
			ST_FIN_TAKE: cmd.op = OP_RES_DATA;
			ST_DONE:     cmd.op = stat.out_free ? OP_OUT : OP_NOP;
			default:     cmd.op = OP_NOP;
		endcase
	end
endmodule

// ===== src/tlca_dp.sv =====
// Datapath: jump table, depth store, node registers and output register.
module tlca_dp #(
	parameter int MAX_NODES = tlca_pkg::MAX_NODES_DEF,
	parameter int LEVELS    = tlca_pkg::LEVELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tlca_pkg::cmd_t              cmd,
	output tlca_pkg::status_t           stat,
	input  logic                        in_func,
	input  logic [tlca_pkg::NODE_W-1:0] in_a,
	input  logic [tlca_pkg::NODE_W-1:0] in_b,
	input  logic                        cfg_we,
	input  logic [tlca_pkg::NODE_W-1:0] cfg_wdata,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tlca_pkg::NODE_W-1:0] out_anc
);
	import tlca_pkg::*;

	localparam int NODES = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
	localparam int N_W   = $clog2(NODES);
	localparam int K_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int DEP_W = LEVELS;
	localparam int JA_W  = $clog2(NODES * LEVELS);

	logic [NODE_W-1:0] node_count_q, a_q, b_q, x_q, y_q, cur_q, ax_q, res_q;
	logic [N_W-1:0]    n_q;
	logic [K_W-1:0]    k_q, k_prev;
	logic [DEP_W-1:0]  d_q, da_q, diff_q, d_new;
	logic              stale_q, rd_zero_q;

	logic              j_we;
	logic [JA_W-1:0]   j_waddr, j_raddr;
	logic [NODE_W-1:0] j_wdata, j_rdata, jdata, rd_node;
	logic              d_we;
	logic [N_W-1:0]    d_raddr;
	logic [DEP_W-1:0]  ddata;
	logic              a_ok, b_ok;

	function automatic logic [JA_W-1:0] ja(input logic [K_W-1:0] k, input logic [NODE_W-1:0] x);
		ja = JA_W'(k) * JA_W'(NODES) + JA_W'(x);
	endfunction

	tlca_ram #(.WIDTH(NODE_W), .DEPTH(NODES * LEVELS)) u_jump (
		.clk   (clk),
		.we    (j_we),
		.waddr (j_waddr),
		.wdata (j_wdata),
		.raddr (j_raddr),
		.rdata (j_rdata)
	);

	tlca_ram #(.WIDTH(DEP_W), .DEPTH(NODES)) u_depth (
		.clk   (clk),
		.we    (d_we),
		.waddr (n_q),
		.wdata (d_new),
		.raddr (d_raddr),
		.rdata (ddata)
	);

	// node 0 has no ancestors at any level
	assign jdata  = rd_zero_q ? '0 : j_rdata;
	assign k_prev = K_W'(k_q - 1'b1);
	assign d_new  = d_q + ((jdata != '0) ? (DEP_W'(1) << k_q) : '0);
	assign a_ok   = (in_a != '0) && (32'(in_a) < 32'(MAX_NODES));
	assign b_ok   = 32'(in_b) < 32'(MAX_NODES);

	always_comb begin
		stat.is_query = in_func;
		stat.in_range = (in_a != '0) && (in_b != '0) && (in_a <= node_count_q)
			&& (in_b <= node_count_q) && (32'(in_a) < 32'(MAX_NODES))
			&& (32'(in_b) < 32'(MAX_NODES));
		stat.stale    = stale_q;
		stat.k_zero   = (k_q == '0);
		stat.k_last   = (k_q == K_W'(LEVELS - 1));
		stat.n_last   = (n_q == N_W'(NODES - 1));
		stat.diff_bit = diff_q[k_q];
		stat.x_eq_y   = (x_q == y_q);
		stat.out_free = !out_valid || out_ready;
	end

	always_comb begin
		j_we    = 1'b0;
		j_waddr = ja(k_q, NODE_W'(n_q));
		j_wdata = jdata;
		j_raddr = ja(k_q, x_q);
		rd_node = x_q;
		d_we    = 1'b0;
		d_raddr = N_W'(a_q);
		unique case (cmd.op)
			OP_ACCEPT: begin
				j_we    = !in_func && a_ok;
				j_waddr = ja('0, in_a);
				j_wdata = b_ok ? in_b : '0;
			end
			OP_RB_RD1: begin
				j_raddr = ja(k_prev, NODE_W'(n_q));
				rd_node = NODE_W'(n_q);
			end
			OP_RB_RD2: begin
				j_raddr = ja(k_prev, jdata);
				rd_node = jdata;
			end
			OP_RB_WR: j_we = 1'b1;
			OP_DP_RD: begin
				j_raddr = ja(k_q, cur_q);
				rd_node = cur_q;
			end
			OP_DP_STEP: d_we = (k_q == '0);
			OP_Q_RDB:   d_raddr = N_W'(b_q);
			OP_BY: begin
				j_raddr = ja(k_q, y_q);
				rd_node = y_q;
			end
			OP_FIN_RD: j_raddr = ja('0, x_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_W'(1);
			stale_q      <= 1'b1;
			out_valid    <= 1'b0;
			n_q          <= '0;
			k_q          <= '0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (cmd.op == OP_OUT) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (cmd.op)
				OP_ACCEPT: begin
					n_q <= '0;
					k_q <= K_W'(1);
					if (!in_func && a_ok) begin
						stale_q <= 1'b1;
					end
				end
				OP_RB_WR: begin
					if (n_q == N_W'(NODES - 1)) begin
						n_q <= '0;
						k_q <= K_W'(k_q + 1'b1);
					end else begin
						n_q <= N_W'(n_q + 1'b1);
					end
				end
				OP_DP_START: k_q <= K_W'(LEVELS - 1);
				OP_DP_STEP: begin
					if (k_q == '0) begin
						n_q <= N_W'(n_q + 1'b1);
					end else begin
						k_q <= k_prev;
					end
				end
				OP_Q_RDA:  stale_q <= 1'b0;
				OP_Q_SWAP: k_q <= K_W'(LEVELS - 1);
				OP_KINIT:  k_q <= K_W'(LEVELS - 1);
				OP_KDEC, OP_LF_TAKE, OP_BC: k_q <= k_prev;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_zero_q <= (rd_node == '0);
		unique case (cmd.op)
			OP_ACCEPT: begin
				a_q   <= in_a;
				b_q   <= in_b;
				res_q <= '0;
			end
			OP_DP_START: begin
				cur_q <= NODE_W'(n_q);
				d_q   <= '0;
			end
			OP_DP_STEP: begin
				if (jdata != '0) begin
					cur_q <= jdata;
				end
				d_q <= d_new;
			end
			OP_Q_RDB: da_q <= ddata;
			OP_Q_SWAP: begin
				if (da_q < ddata) begin
					x_q    <= b_q;
					y_q    <= a_q;
					diff_q <= ddata - da_q;
				end else begin
					x_q    <= a_q;
					y_q    <= b_q;
					diff_q <= da_q - ddata;
				end
			end
			OP_LF_TAKE: x_q <= jdata;
			OP_BY:      ax_q <= jdata;
			OP_BC: begin
				if (ax_q != jdata) begin
					x_q <= ax_q;
					y_q <= jdata;
				end
			end
			OP_RES_X:    res_q <= x_q;
			OP_RES_DATA: res_q <= jdata;
			OP_OUT:      out_anc <= res_q;
			default: ;
		endcase
	end
endmodule

// ===== test/tree_lca_binary_lifting_test.sv =====
// Self-checking stream testbench of the binary-lifting common-ancestor block.
module tree_lca_binary_lifting_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tlca_pkg::*;

	localparam int NODES      = MAX_NODES_DEF;
	localparam int LVL        = LEVELS_DEF;
	localparam int IDLE_LIMIT = 500000;
	localparam int HOLD_LEN   = 400;

	typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_t;
	typedef struct {
		row_kind_t          kind;
		logic [NODE_W-1:0]  a;
		logic [NODE_W-1:0]  b;
		bit                 has_exp;
		logic [NODE_W-1:0]  exp_v;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        cfg_we;
	logic [9:0]  cfg_wdata;

	tree_lca_binary_lifting DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [NODE_W-1:0] lift [0:NODES-1][0:LVL-1];
	int                depth_of [0:NODES-1];
	bit                parent_set [0:NODES-1];
	bit                lift_stale;
	int                node_limit;

	logic [NODE_W-1:0] ancestor_q [$];
	logic [NODE_W-1:0] loaded_nodes [$];
	bit  in_go, out_go;
	logic [NODE_W-1:0] out_anc;
	bit  hold_req, smooth;
	int  fails, items_sent, results_seen, rebuilds, idle_cycles;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void rebuild_lift();
		int cur, d;
		for (int k = 1; k < LVL; k++)
			for (int x = 0; x < NODES; x++)
				lift[x][k] = lift[lift[x][k-1]][k-1];
		for (int x = 0; x < NODES; x++) begin
			cur = x;
			d = 0;
			for (int k = LVL - 1; k >= 0; k--)
				if (lift[cur][k] != 0) begin
					cur = lift[cur][k];
					d += 1 << k;
				end
			depth_of[x] = d;
		end
		lift_stale = 0;
		rebuilds++;
	endfunction

	function automatic logic [NODE_W-1:0] common_of(int x, int y);
		int t, diff;
		if (depth_of[x] < depth_of[y]) begin
			t = x; x = y; y = t;
		end
		diff = depth_of[x] - depth_of[y];
		for (int k = LVL - 1; k >= 0; k--)
			if ((diff >> k) & 1) x = lift[x][k];
		if (x == y) return x;
		for (int k = LVL - 1; k >= 0; k--)
			if (lift[x][k] != lift[y][k]) begin
				x = lift[x][k];
				y = lift[y][k];
			end
		return lift[x][0];
	endfunction

	function automatic logic [NODE_W-1:0] predict_query(int a, int b);
		if (a == 0 || b == 0 || a > node_limit || b > node_limit) return '0;
		if (lift_stale) rebuild_lift();
		return common_of(a, b);
	endfunction

	function automatic void predict_load(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
		if (a != 0) begin
			lift[a][0] = b;
			if (!parent_set[a]) loaded_nodes.push_back(a);
			parent_set[a] = 1;
			lift_stale = 1;
		end
	endfunction

	// every node on the chain must have had its parent loaded; a cycle is fine
	function automatic bit chain_known(int x);
		for (int i = 0; i < 2 * NODES + 4; i++) begin
			if (x == 0) return 1;
			if (!parent_set[x]) return 0;
			x = lift[x][0];
		end
		return 1;
	endfunction

	function automatic bit query_safe(int a, int b);
		if (a == 0 || b == 0 || a > node_limit || b > node_limit) return 1;
		return chain_known(a) && chain_known(b);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (smooth || r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	function automatic logic [NODE_W-1:0] pick_loaded();
		if (loaded_nodes.size() == 0) return 10'd1;
		return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
	endfunction

	// handshakes sampled mid-cycle, so the edge ordering cannot matter
	always @(negedge clk) begin
		in_go   = s_axis_tvalid && s_axis_tready;
		out_go  = m_axis_tvalid && m_axis_tready;
		out_anc = m_axis_tdata[NODE_W-1:0];
	end

	always @(posedge clk) begin
		if (out_go) begin
			results_seen++;
			if (ancestor_q.size() == 0) begin
				$error("unexpected item: ancestor %0d", out_anc);
				fails++;
			end else if (ancestor_q[0] !== out_anc) begin
				$error("ancestor: expected %0d, actual %0d", ancestor_q[0], out_anc);
				fails++;
				void'(ancestor_q.pop_front());
			end else
				void'(ancestor_q.pop_front());
		end
	end

	always @(posedge clk) begin
		if (in_go || out_go || cfg_we) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
			$display("tree_lca_binary_lifting_test failed");
			$finish;
		end
	end

	// receiver
	initial begin
		int r;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			r = $urandom_range(0, 99);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_req = 0;
			end else if (smooth || r < 65)
				m_axis_tready <= 1'b1;
			else if (r < 95)
				m_axis_tready <= 1'b0;
			else begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(15, 70)) @(posedge clk);
			end
		end
	end

	task automatic send_item(bit q, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
			bit has_exp, logic [NODE_W-1:0] exp_v);
		int gap;
		logic [NODE_W-1:0] p;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= q;
		s_axis_tdata  <= {4'd0, b, a};
		do @(posedge clk); while (!in_go);
		items_sent++;
		if (q) begin
			p = predict_query(a, b);
			ancestor_q.push_back(has_exp ? exp_v : p);
		end else
			predict_load(a, b);
	endtask

	task automatic write_count(logic [9:0] v);
		s_axis_tvalid <= 1'b0;
		while (ancestor_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		node_limit = v;
	endtask

	task automatic random_phase(int n_loads, int n_queries, int mix);
		logic [NODE_W-1:0] a, b;
		int r;
		for (int i = 0; i < n_loads; i++) begin
			r = $urandom_range(0, 99);
			a = (r < 4) ? 10'd0 : (r < 30) ? 10'($urandom_range(1, 40))
				: 10'($urandom_range(1, NODES - 1));
			r = $urandom_range(0, 99);
			b = (r < 6) ? 10'd0 : (r < 10) ? 10'($urandom_range(0, NODES - 1))
				: pick_loaded();
			send_item(0, a, b, 0, '0);
		end
		for (int i = 0; i < n_queries; i++) begin
			if (mix > 0 && $urandom_range(0, 99) < mix) begin
				a = 10'($urandom_range(1, NODES - 1));
				send_item(0, a, pick_loaded(), 0, '0);
			end
			r = $urandom_range(0, 99);
			if (r < 80) begin
				a = pick_loaded();
				b = ($urandom_range(0, 3) == 0) ? a : pick_loaded();
			end else begin
				a = 10'($urandom_range(0, NODES - 1));
				b = 10'($urandom_range(0, NODES - 1));
			end
			if (!query_safe(a, b)) a = '0;
			send_item(1, a, b, 0, '0);
		end
	endtask

	row_t rows [] = '{
		'{ROW_QUERY, 10'd0,    10'd0,    1, 10'd0},
		'{ROW_QUERY, 10'd1023, 10'd1023, 1, 10'd0},
		'{ROW_LOAD,  10'd1,    10'd0,    0, 10'd0},
		'{ROW_QUERY, 10'd1,    10'd1,    1, 10'd1},
		'{ROW_LOAD,  10'd0,    10'd1023, 0, 10'd0},
		'{ROW_CFG,   10'd0,    10'd1023, 0, 10'd0},
		'{ROW_LOAD,  10'd1023, 10'd1,    0, 10'd0},
		'{ROW_LOAD,  10'd2,    10'd1,    0, 10'd0},
		'{ROW_LOAD,  10'd3,    10'd2,    0, 10'd0},
		'{ROW_LOAD,  10'd512,  10'd3,    0, 10'd0},
		'{ROW_LOAD,  10'd4,    10'd1023, 0, 10'd0},
		'{ROW_QUERY, 10'd512,  10'd4,    1, 10'd1},
		'{ROW_QUERY, 10'd3,    10'd512,  0, 10'd0},
		'{ROW_QUERY, 10'd1023, 10'd1023, 0, 10'd0},
		'{ROW_QUERY, 10'd0,    10'd5,    1, 10'd0},
		'{ROW_QUERY, 10'd5,    10'd0,    1, 10'd0},
		'{ROW_QUERY, 10'd1023, 10'd1,    1, 10'd1},
		'{ROW_LOAD,  10'd700,  10'd701,  0, 10'd0},
		'{ROW_LOAD,  10'd701,  10'd700,  0, 10'd0},
		'{ROW_QUERY, 10'd700,  10'd701,  0, 10'd0},
		'{ROW_QUERY, 10'd700,  10'd2,    0, 10'd0},
		'{ROW_CFG,   10'd0,    10'd3,    0, 10'd0},
		'{ROW_QUERY, 10'd512,  10'd3,    1, 10'd0},
		'{ROW_QUERY, 10'd1,    10'd3,    0, 10'd0}
	};

	initial begin
		for (int x = 0; x < NODES; x++) begin
			for (int k = 0; k < LVL; k++) lift[x][k] = '0;
			depth_of[x] = 0;
			parent_set[x] = 0;
		end
		lift_stale = 1;
		node_limit = 1;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser  <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) write_count(rows[i].b);
			else send_item(rows[i].kind == ROW_QUERY, rows[i].a, rows[i].b,
				rows[i].has_exp, rows[i].exp_v);
		end

		write_count(10'd1023);
		random_phase(80, 110, 0);
		write_count(10'd1);
		random_phase(40, 90, 0);
		write_count(10'($urandom_range(200, 1022)));
		hold_req = 1;
		random_phase(60, 110, 3);
		write_count(10'd1023);
		smooth = 1;
		random_phase(70, 110, 0);
		smooth = 0;
		write_count(10'($urandom_range(2, 199)));
		random_phase(50, 100, 0);
		write_count(10'd1023);
		random_phase(30, 60, 2);

		s_axis_tvalid <= 1'b0;
		while (ancestor_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d input items, %0d results, %0d table rebuilds,",
			items_sent, results_seen, rebuilds);
		$display("node counts 1 to 1023, cyclic and split trees, out-of-range queries");
		if (fails == 0 && ancestor_q.size() == 0)
			$display("tree_lca_binary_lifting_test passed");
		else
			$display("tree_lca_binary_lifting_test failed");
		$finish;
	end
endmodule

// ===== sim.f =====
src/tlca_pkg.sv
src/tlca_ram.sv
src/tlca_ctrl.sv
src/tlca_dp.sv
src/tree_lca_binary_lifting.sv
test/tree_lca_binary_lifting_test.sv
